### rtl/core/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Dual timer/counter package
// Shared codes, register layout and bit positions for the timer block.
// ----------------------------------------------------------------------------
package dtc_pkg;

   // transaction kinds on the request channel
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // register selects
   localparam logic [2:0] SEL_CONTROL = 3'd0;
   localparam logic [2:0] SEL_LOW0    = 3'd1;
   localparam logic [2:0] SEL_HIGH0   = 3'd2;
   localparam logic [2:0] SEL_LOW1    = 3'd3;
   localparam logic [2:0] SEL_HIGH1   = 3'd4;

   // configuration register indexes
   localparam logic CSR_TIMER_MODE    = 1'b0;
   localparam logic CSR_TIMERS_PRESENT = 1'b1;

   localparam logic [7:0] TIMER_MODE_RESET     = 8'h00;
   localparam logic [1:0] TIMERS_PRESENT_RESET = 2'b11;

   // control register bit positions
   localparam int TF1_BIT = 7;
   localparam int TR1_BIT = 6;
   localparam int TF0_BIT = 5;
   localparam int TR0_BIT = 4;

   // per-timer mode codes
   localparam logic [1:0] TMODE_13BIT  = 2'd0;
   localparam logic [1:0] TMODE_16BIT  = 2'd1;
   localparam logic [1:0] TMODE_RELOAD = 2'd2;
   localparam logic [1:0] TMODE_SPLIT  = 2'd3;

   // low five bits all set: 13-bit prescaler wraps
   localparam logic [4:0] PRESCALE_MAX = 5'h1F;

   typedef struct packed {
      logic [7:0] tl;
      logic [7:0] th;
      logic       ovf;
   } pair_type;

endpackage

### rtl/core/dual_timer_counter.sv
// ----------------------------------------------------------------------------
// Dual timer/counter
// Two classic microcontroller timer/counters with 13-bit, 16-bit, auto-reload
// and split modes, plus byte access to the control and count registers.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_*) carries one transaction per item: a tick that
//   steps timer 0 and then timer 1, a byte write, or a byte read of the
//   control register or one of the four count bytes. Pins are sampled with
//   the tick. Each request yields exactly one response transaction (rsp_*)
//   carrying read data (zero unless a read) and the two overflow indications.
//   The csr_* port writes the mode register and the timer-enable mask; write
//   it only while no transaction is outstanding.
// Timing and throughput:
//   The state updates on the accepting edge and the response is registered
//   on that same edge. One transaction per cycle while the response side
//   does not stall.
// Reset:
//   Clears the control and count registers, the mode register, sets both
//   timers present and empties the response register.
// Stall:
//   While rsp_ready is low a held response stays put and req_ready drops, so
//   no request is taken until the response slot frees; when the receiver
//   takes the response, a new request is accepted in the same cycle.
// ----------------------------------------------------------------------------
module dual_timer_counter (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [2:0] req_reg_select,
   input  logic [7:0] req_write_data,
   input  logic       req_pin_int0,
   input  logic       req_pin_int1,
   input  logic       req_pin_count0,
   input  logic       req_pin_count1,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq_timer0,
   output logic       rsp_irq_timer1,
   // configuration port
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   // Step one TL/TH pair in 13-bit, 16-bit or auto-reload mode.
   function automatic dtc_pkg::pair_type step_pair(input logic [1:0] m,
                                                   input logic [7:0] tl,
                                                   input logic [7:0] th);
      dtc_pkg::pair_type r;
      r.tl  = tl;
      r.th  = th;
      r.ovf = 1'b0;
      case (m)
         dtc_pkg::TMODE_13BIT: begin
            if (tl[4:0] == dtc_pkg::PRESCALE_MAX) begin
               r.tl  = 8'h00;
               r.ovf = (th == 8'hFF);
               r.th  = th + 8'd1;
            end else begin
               r.tl = tl + 8'd1;
            end
         end
         dtc_pkg::TMODE_16BIT: begin
            if (tl == 8'hFF) begin
               r.ovf = (th == 8'hFF);
               r.th  = th + 8'd1;
            end
            r.tl = tl + 8'd1;
         end
         dtc_pkg::TMODE_RELOAD: begin
            if (tl == 8'hFF) begin
               r.tl  = th;
               r.ovf = 1'b1;
            end else begin
               r.tl = tl + 8'd1;
            end
         end
         default: begin
            // split mode is handled outside this helper
         end
      endcase
      return r;
   endfunction

   // configuration
   logic [7:0] tmod_ff;
   logic [1:0] present_ff;

   // architectural state
   logic [7:0] control_ff, control_in;
   logic [7:0] low0_ff, low0_in;
   logic [7:0] high0_ff, high0_in;
   logic [7:0] low1_ff, low1_in;
   logic [7:0] high1_ff, high1_in;

   // response register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_irq0_ff, rsp_irq0_in;
   logic       rsp_irq1_ff, rsp_irq1_in;

   logic req_fire;

   // Take a new request whenever the response slot is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Decode the mode register fields.
   logic [1:0] m0, m1;
   logic       ct0, gate0, ct1, gate1, split;
   logic       run0, run1_qual;
   dtc_pkg::pair_type pair0, pair1;

   assign m0    = tmod_ff[1:0];
   assign ct0   = tmod_ff[2];
   assign gate0 = tmod_ff[3];
   assign m1    = tmod_ff[5:4];
   assign ct1   = tmod_ff[6];
   assign gate1 = tmod_ff[7];
   assign split = (m0 == dtc_pkg::TMODE_SPLIT);

   // A timer runs when enabled, not gated off, and not a counter with pin low.
   assign run0 = control_ff[dtc_pkg::TR0_BIT] && !(gate0 && !req_pin_int0)
               && !(ct0 && !req_pin_count0);
   assign run1_qual = control_ff[dtc_pkg::TR1_BIT] && !(gate1 && !req_pin_int1)
                    && !(ct1 && !req_pin_count1);

   assign pair0 = step_pair(m0, low0_ff, high0_ff);
   assign pair1 = step_pair(m1, low1_ff, high1_ff);

   always_comb begin
      control_in  = control_ff;
      low0_in     = low0_ff;
      high0_in    = high0_ff;
      low1_in     = low1_ff;
      high1_in    = high1_ff;
      rsp_data_in = 8'h00;
      rsp_irq0_in = 1'b0;
      rsp_irq1_in = 1'b0;
      case (req_mode)
         dtc_pkg::MODE_TICK: begin
            // timer 0 (TL0 alone in split mode)
            if (present_ff[0] && run0) begin
               if (split) begin
                  rsp_irq0_in = (low0_ff == 8'hFF);
                  low0_in     = low0_ff + 8'd1;
               end else begin
                  rsp_irq0_in = pair0.ovf;
                  low0_in     = pair0.tl;
                  high0_in    = pair0.th;
               end
            end
            if (present_ff[1]) begin
               // timer 1 runs free and flagless while timer 0 is split; it halts in split mode
               if ((split || run1_qual) && m1 != dtc_pkg::TMODE_SPLIT) begin
                  low1_in  = pair1.tl;
                  high1_in = pair1.th;
                  if (pair1.ovf && !split) begin
                     rsp_irq1_in = 1'b1;
                  end
               end
               // split TH0 borrows TR1 and TF1; TH0 is untouched by timer 0 here
               if (split && control_ff[dtc_pkg::TR1_BIT]) begin
                  if (high0_ff == 8'hFF) begin
                     rsp_irq1_in = 1'b1;
                  end
                  high0_in = high0_ff + 8'd1;
               end
            end
            // overflow ORs the sticky flags
            if (rsp_irq0_in) begin
               control_in[dtc_pkg::TF0_BIT] = 1'b1;
            end
            if (rsp_irq1_in) begin
               control_in[dtc_pkg::TF1_BIT] = 1'b1;
            end
         end
         dtc_pkg::MODE_WRITE: begin
            case (req_reg_select)
               dtc_pkg::SEL_CONTROL: control_in = req_write_data;
               dtc_pkg::SEL_LOW0:    low0_in    = req_write_data;
               dtc_pkg::SEL_HIGH0:   high0_in   = req_write_data;
               dtc_pkg::SEL_LOW1:    low1_in    = req_write_data;
               dtc_pkg::SEL_HIGH1:   high1_in   = req_write_data;
               default: begin
                  // unused select: drop the write
               end
            endcase
         end
         dtc_pkg::MODE_READ: begin
            case (req_reg_select)
               dtc_pkg::SEL_CONTROL: rsp_data_in = control_ff;
               dtc_pkg::SEL_LOW0:    rsp_data_in = low0_ff;
               dtc_pkg::SEL_HIGH0:   rsp_data_in = high0_ff;
               dtc_pkg::SEL_LOW1:    rsp_data_in = low1_ff;
               dtc_pkg::SEL_HIGH1:   rsp_data_in = high1_ff;
               default:              rsp_data_in = 8'h00;
            endcase
         end
         default: begin
            // unused kind: no effect, all-zero response
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tmod_ff    <= dtc_pkg::TIMER_MODE_RESET;
         present_ff <= dtc_pkg::TIMERS_PRESENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dtc_pkg::CSR_TIMER_MODE:     tmod_ff    <= csr_wdata;
            dtc_pkg::CSR_TIMERS_PRESENT: present_ff <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Architectural state advances on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= 8'h00;
         low0_ff    <= 8'h00;
         high0_ff   <= 8'h00;
         low1_ff    <= 8'h00;
         high1_ff   <= 8'h00;
      end else if (req_fire) begin
         control_ff <= control_in;
         low0_ff    <= low0_in;
         high0_ff   <= high0_in;
         low1_ff    <= low1_in;
         high1_ff   <= high1_in;
      end
   end

   // Response slot: load on accept, hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq0_ff <= rsp_irq0_in;
         rsp_irq1_ff <= rsp_irq1_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_irq_timer0 = rsp_irq0_ff;
   assign rsp_irq_timer1 = rsp_irq1_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_no_irq_off_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode != dtc_pkg::MODE_TICK)
         |=> (!rsp_irq_timer0 && !rsp_irq_timer1))
      else $error("overflow reported on a non-tick transaction");

   a_no_data_off_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode != dtc_pkg::MODE_READ) |=> (rsp_read_data == 8'h00))
      else $error("read data nonzero on a non-read transaction");

   a_irq0_sets_tf0: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (!rsp_irq_timer0 || control_ff[dtc_pkg::TF0_BIT]))
      else $error("timer 0 overflow without TF0 set");

   a_irq1_sets_tf1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (!rsp_irq_timer1 || control_ff[dtc_pkg::TF1_BIT]))
      else $error("timer 1 overflow without TF1 set");

   a_tf0_sticky_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == dtc_pkg::MODE_TICK && control_ff[dtc_pkg::TF0_BIT])
         |=> control_ff[dtc_pkg::TF0_BIT])
      else $error("TF0 cleared by a tick");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Dual timer/counter testbench
// Drives tick, write and read transactions with random pins and random gaps
// on both channels. A scoreboard class keeps its own copy of the control
// register, the count bytes and the mode settings, predicts every response
// and compares each one field by field. The run steps through many mode
// settings and timer-enable masks, and preloads counters near overflow so
// that every mode wraps often.
// ----------------------------------------------------------------------------
module tb;

   // mode code the block does not use; such a transaction must do nothing
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // highest select code, beyond the last count byte
   localparam logic [2:0] SEL_UNUSED  = 3'd7;
   localparam int         PHASES      = 15;
   localparam int         PHASE_ITEMS = 87;
   localparam int         QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq0;
      logic       irq1;
   } timer_result_type;

   // Scoreboard: shadow state of the timer pair and the responses still owed
   class timer_scoreboard;
      logic [7:0]       tmod;
      logic [1:0]       present;
      logic [7:0]       tcon;
      logic [7:0]       tl0;
      logic [7:0]       th0;
      logic [7:0]       tl1;
      logic [7:0]       th1;
      timer_result_type pending_results[$];
      int               failures;

      function new();
         tmod     = dtc_pkg::TIMER_MODE_RESET;
         present  = dtc_pkg::TIMERS_PRESENT_RESET;
         tcon     = 8'h00;
         tl0      = 8'h00;
         th0      = 8'h00;
         tl1      = 8'h00;
         th1      = 8'h00;
         failures = 0;
      endfunction

      function void write_csr(logic idx, logic [7:0] data);
         if (idx == dtc_pkg::CSR_TIMER_MODE)
            tmod = data;
         else
            present = data[1:0];
      endfunction

      // advance one low/high pair in 13-bit, 16-bit or reload mode
      function bit advance_pair(logic [1:0] m, inout logic [7:0] lo, inout logic [7:0] hi);
         bit wrap;
         wrap = 1'b0;
         case (m)
            dtc_pkg::TMODE_13BIT: begin
               if (lo[4:0] == dtc_pkg::PRESCALE_MAX) begin
                  lo   = 8'h00;
                  wrap = (hi == 8'hFF);
                  hi   = hi + 8'd1;
               end else begin
                  lo = lo + 8'd1;
               end
            end
            dtc_pkg::TMODE_16BIT: begin
               if (lo == 8'hFF) begin
                  wrap = (hi == 8'hFF);
                  hi   = hi + 8'd1;
               end
               lo = lo + 8'd1;
            end
            dtc_pkg::TMODE_RELOAD: begin
               if (lo == 8'hFF) begin
                  lo   = hi;
                  wrap = 1'b1;
               end else begin
                  lo = lo + 8'd1;
               end
            end
            default: ;
         endcase
         return wrap;
      endfunction

      function bit timer_runs(bit tr, bit gate, bit counter, bit pin_int, bit pin_cnt);
         return tr && !(gate && !pin_int) && !(counter && !pin_cnt);
      endfunction

      // predict the response of one accepted request and update the shadow
      function void note_request(logic [1:0] mode, logic [2:0] sel, logic [7:0] wdata,
                                 logic int0, logic int1, logic cnt0, logic cnt1);
         timer_result_type r;
         logic [1:0]       m0;
         logic [1:0]       m1;
         bit               split;
         bit               wrap;
         r     = '0;
         m0    = tmod[1:0];
         m1    = tmod[5:4];
         split = (m0 == dtc_pkg::TMODE_SPLIT);
         case (mode)
            dtc_pkg::MODE_TICK: begin
               if (present[0] &&
                   timer_runs(tcon[dtc_pkg::TR0_BIT], tmod[3], tmod[2], int0, cnt0)) begin
                  if (split) begin
                     wrap = (tl0 == 8'hFF);
                     tl0  = tl0 + 8'd1;
                  end else begin
                     wrap = advance_pair(m0, tl0, th0);
                  end
                  if (wrap) begin
                     tcon[dtc_pkg::TF0_BIT] = 1'b1;
                     r.irq0                 = 1'b1;
                  end
               end
               if (present[1]) begin
                  // with timer 0 split, timer 1 runs free and flags nothing; it halts in split mode
                  if ((split ||
                       timer_runs(tcon[dtc_pkg::TR1_BIT], tmod[7], tmod[6], int1, cnt1))
                      && m1 != dtc_pkg::TMODE_SPLIT) begin
                     wrap = advance_pair(m1, tl1, th1);
                     if (wrap && !split) begin
                        tcon[dtc_pkg::TF1_BIT] = 1'b1;
                        r.irq1                 = 1'b1;
                     end
                  end
                  // split high half of timer 0 borrows TR1 and TF1
                  if (split && tcon[dtc_pkg::TR1_BIT]) begin
                     if (th0 == 8'hFF) begin
                        tcon[dtc_pkg::TF1_BIT] = 1'b1;
                        r.irq1                 = 1'b1;
                     end
                     th0 = th0 + 8'd1;
                  end
               end
            end
            dtc_pkg::MODE_WRITE: begin
               case (sel)
                  dtc_pkg::SEL_CONTROL: tcon = wdata;
                  dtc_pkg::SEL_LOW0:    tl0  = wdata;
                  dtc_pkg::SEL_HIGH0:   th0  = wdata;
                  dtc_pkg::SEL_LOW1:    tl1  = wdata;
                  dtc_pkg::SEL_HIGH1:   th1  = wdata;
                  default: ;
               endcase
            end
            dtc_pkg::MODE_READ: begin
               case (sel)
                  dtc_pkg::SEL_CONTROL: r.read_data = tcon;
                  dtc_pkg::SEL_LOW0:    r.read_data = tl0;
                  dtc_pkg::SEL_HIGH0:   r.read_data = th0;
                  dtc_pkg::SEL_LOW1:    r.read_data = tl1;
                  dtc_pkg::SEL_HIGH1:   r.read_data = th1;
                  default:              r.read_data = 8'h00;
               endcase
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [7:0] read_data, logic irq0, logic irq1);
         timer_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response read_data %h irq0 %b irq1 %b",
                     $time, read_data, irq0, irq1);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         if (want.read_data !== read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
            failures++;
         end
         if (want.irq0 !== irq0) begin
            $display("%0t: irq_timer0 expected %b actual %b", $time, want.irq0, irq0);
            failures++;
         end
         if (want.irq1 !== irq1) begin
            $display("%0t: irq_timer1 expected %b actual %b", $time, want.irq1, irq1);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode       = dtc_pkg::MODE_TICK;
   logic [2:0] req_reg_select = dtc_pkg::SEL_CONTROL;
   logic [7:0] req_write_data = 8'h00;
   logic       req_pin_int0   = 1'b0;
   logic       req_pin_int1   = 1'b0;
   logic       req_pin_count0 = 1'b0;
   logic       req_pin_count1 = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq_timer0;
   logic       rsp_irq_timer1;
   logic       csr_we         = 1'b0;
   logic       csr_index      = dtc_pkg::CSR_TIMER_MODE;
   logic [7:0] csr_wdata      = 8'h00;

   timer_scoreboard board;
   bit              steady = 1'b0;   // suppress all idling on both sides
   int              quiet_cycles = 0;

   dual_timer_counter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_reg_select (req_reg_select),
      .req_write_data (req_write_data),
      .req_pin_int0   (req_pin_int0),
      .req_pin_int1   (req_pin_int1),
      .req_pin_count0 (req_pin_count0),
      .req_pin_count1 (req_pin_count1),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_timer0 (rsp_irq_timer0),
      .rsp_irq_timer1 (rsp_irq_timer1),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Stall the response side about 7 percent of the time, unless steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 7);
   end

   // Sample both handshakes on the edge; check the response before noting
   // the new request so the queue keeps transaction order
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_read_data, rsp_irq_timer0, rsp_irq_timer1);
         if (req_valid && req_ready)
            board.note_request(req_mode, req_reg_select, req_write_data, req_pin_int0,
                               req_pin_int1, req_pin_count0, req_pin_count1);
      end
   end

   // Count cycles in which no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Offer one request and hold it until the block takes it.
   // pins is {count1, count0, int1, int0}.
   task automatic send_request(logic [1:0] mode, logic [2:0] sel, logic [7:0] wdata,
                               logic [3:0] pins);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_reg_select <= sel;
      req_write_data <= wdata;
      req_pin_int0   <= pins[0];
      req_pin_int1   <= pins[1];
      req_pin_count0 <= pins[2];
      req_pin_count1 <= pins[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every owed response has been taken
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // Write both configuration registers; call only while idle
   task automatic configure(logic [7:0] mode_bits, logic [1:0] present_bits);
      csr_we    <= 1'b1;
      csr_index <= dtc_pkg::CSR_TIMER_MODE;
      csr_wdata <= mode_bits;
      board.write_csr(dtc_pkg::CSR_TIMER_MODE, mode_bits);
      @(posedge clock);
      csr_index <= dtc_pkg::CSR_TIMERS_PRESENT;
      csr_wdata <= {6'b0, present_bits};
      board.write_csr(dtc_pkg::CSR_TIMERS_PRESENT, {6'b0, present_bits});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Favor count values one step short of a wrap in every mode
   function automatic logic [7:0] pick_count_byte();
      case ($urandom_range(3))
         0:       return 8'hFF;
         1:       return 8'hFE;
         2:       return {3'($urandom_range(7)), dtc_pkg::PRESCALE_MAX};
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Each pin is high three times in four so gated timers mostly run
   function automatic logic [3:0] pick_pins();
      logic [3:0] p;
      for (int i = 0; i < 4; i++)
         p[i] = ($urandom_range(3) != 0);
      return p;
   endfunction

   initial begin
      logic [7:0] mode_plan [0:8];
      logic [1:0] present_plan [0:3];
      logic [7:0] mode_bits;
      logic [1:0] present_bits;
      logic [7:0] ctrl;
      int unsigned pick;

      board = new();
      // extremes first, then one mode on both timers, split with each timer 1 mode, then gated counters
      mode_plan    = '{8'h00, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h03, 8'h23, 8'h13, 8'hCC};
      present_plan = '{2'b11, 2'b00, 2'b01, 2'b10};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: reset values, 13-bit wrap of both timers, odd codes ----
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_CONTROL, 8'h00, 4'h0);
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_CONTROL, 8'h50, 4'h0);  // TR0, TR1
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_LOW0,    8'h1F, 4'h0);
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_HIGH0,   8'hFF, 4'h0);
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_LOW1,    8'hFF, 4'h0);
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_HIGH1,   8'hFF, 4'h0);
      send_request(dtc_pkg::MODE_TICK,  dtc_pkg::SEL_CONTROL, 8'h00, 4'hF);  // both wrap
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_CONTROL, 8'h00, 4'h0);
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_LOW0,    8'h00, 4'h0);
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_HIGH0,   8'h00, 4'h0);
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_LOW1,    8'h00, 4'h0);
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_HIGH1,   8'h00, 4'h0);
      send_request(dtc_pkg::MODE_TICK,  dtc_pkg::SEL_CONTROL, 8'h00, 4'h0);
      // unused selects and the unused kind
      send_request(dtc_pkg::MODE_WRITE, 3'(dtc_pkg::SEL_HIGH1 + 1), 8'hFF, 4'hF);
      send_request(dtc_pkg::MODE_READ,  SEL_UNUSED,           8'hFF, 4'hF);
      send_request(MODE_UNUSED,         SEL_UNUSED,           8'hFF, 4'hF);
      send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_CONTROL, 8'hFF, 4'h0);  // low nibble
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_CONTROL, 8'h00, 4'h0);
      send_request(dtc_pkg::MODE_TICK,  dtc_pkg::SEL_CONTROL, 8'h00, 4'h0);
      send_request(dtc_pkg::MODE_READ,  dtc_pkg::SEL_LOW0,    8'h00, 4'h0);
      drain_responses();

      // ---- random phases, each under its own mode setting ----
      for (int phase = 0; phase < PHASES; phase++) begin
         mode_bits    = (phase < 9) ? mode_plan[phase] : 8'($urandom_range(255));
         present_bits = (phase < 4) ? present_plan[phase] :
                        (($urandom_range(5) == 0) ? 2'($urandom_range(3)) : 2'b11);
         configure(mode_bits, present_bits);
         steady = (phase == 5);

         // arm: run bits mostly set, counters near a wrap
         ctrl = 8'($urandom_range(255));
         ctrl[dtc_pkg::TR0_BIT] = ($urandom_range(7) != 0);
         ctrl[dtc_pkg::TR1_BIT] = ($urandom_range(7) != 0);
         send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_CONTROL, ctrl, pick_pins());
         send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_LOW0,  pick_count_byte(), pick_pins());
         send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_HIGH0, pick_count_byte(), pick_pins());
         send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_LOW1,  pick_count_byte(), pick_pins());
         send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_HIGH1, pick_count_byte(), pick_pins());

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 62)
               send_request(dtc_pkg::MODE_TICK, 3'($urandom_range(7)),
                            8'($urandom_range(255)), pick_pins());
            else if (pick < 72)
               send_request(dtc_pkg::MODE_READ, 3'($urandom_range(dtc_pkg::SEL_HIGH1)),
                            8'($urandom_range(255)), pick_pins());
            else if (pick < 80)
               send_request(dtc_pkg::MODE_WRITE,
                            3'($urandom_range(dtc_pkg::SEL_HIGH1, dtc_pkg::SEL_LOW0)),
                            pick_count_byte(), pick_pins());
            else if (pick < 86)
               send_request(dtc_pkg::MODE_WRITE, dtc_pkg::SEL_CONTROL,
                            8'($urandom_range(255)), pick_pins());
            else if (pick < 94)
               send_request(2'($urandom_range(dtc_pkg::MODE_READ, dtc_pkg::MODE_WRITE)),
                            3'($urandom_range(7)), 8'($urandom_range(255)), pick_pins());
            else
               send_request(MODE_UNUSED, 3'($urandom_range(7)), 8'($urandom_range(255)),
                            4'($urandom_range(15)));
         end
         // hold off until everything owed has come back
         drain_responses();
      end
      steady = 1'b0;

      // let any stray response show up before the verdict
      repeat (4) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
